### rtl/core/chrl_pkg.sv
// Package for the consistent hash ring lookup block.
// Holds op and status codes and the sequencer state type; no dependencies.
`default_nettype none
package chrl_pkg;
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CONTAINS = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_SHIFT,
		S_EMIT,
		S_OUT
	} state_t;

	localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;
	localparam int unsigned MAX_OUT = 16;
endpackage
`default_nettype wire

### rtl/core/consistent_hash_ring_lookup.sv
// Top level of the consistent hash ring lookup block.
// Uses chrl_pkg for codes and state types; the ring lives in one memory here.
//
// Usage: requests come in on the in channel (in_valid/in_ready), one key byte
// per request. A byte without last_byte only updates the hash and gives no
// result, and the block stays ready. On the last byte the op runs against the
// sorted ring, which is held in a synchronous memory read one entry a cycle.
// The search reads one entry per cycle up to the first position not below the
// key; add and remove then move entries one at a time, each by a read and a
// write, and a lookup reads one entry per result. The memory has a single
// port, and the block takes no new request until the final one is through.
// Results leave through an output register on the out channel; when the
// receiver stalls, the sequencer holds until the register is taken. Reset
// clears the hash, the entry count and the sequencer; the memory contents are
// not cleared, since only entries below the count are ever read.
`default_nettype none
module consistent_hash_ring_lookup #(
	parameter int RING_ENTRIES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] op,
	input  wire logic [7:0] key_byte,
	input  wire logic       last_byte,
	input  wire logic [7:0] node_id,
	input  wire logic [4:0] replicas,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic [7:0]      found_node,
	output logic [4:0]      entry_count,
	output logic            last_result
);
	localparam int AW = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
	localparam int CW = $clog2(RING_ENTRIES + 1);

	logic [39:0] mem [RING_ENTRIES];
	logic [39:0] rdata_q;
	logic [AW-1:0] raddr;
	logic          ren;
	logic [AW-1:0] waddr;
	logic          wen;
	logic [39:0]   wdata;

	chrl_pkg::state_t state_q, state_d;
	logic [31:0] hash_q, key_q;
	logic [CW-1:0] count_q;
	logic [CW:0] idx_q, cur_q;
	logic [4:0] left_q;
	logic [1:0] op_q;
	logic [7:0] nid_q;
	logic [4:0] want_q;
	logic rd_pend_q;

	logic [31:0] hash_next;
	logic accept;
	logic out_free;
	logic out_load;
	logic emit_hold;
	logic [4:0] emit_lim;

	function automatic logic [4:0] sat5(input logic [CW:0] v);
		return (int'(v) > 31) ? 5'd31 : 5'(v);
	endfunction

	assign out_free = !out_valid || out_ready;
	assign hash_next = (hash_q << 5) - hash_q + {24'd0, key_byte};
	assign in_ready = (state_q == chrl_pkg::S_IDLE);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	logic [CW:0] cnt_ext;
	assign cnt_ext = {1'b0, count_q};
	logic ge_key;
	assign ge_key = (rdata_q[39:8] ^ chrl_pkg::SIGN_FLIP) >= (key_q ^ chrl_pkg::SIGN_FLIP);
	logic hit;
	assign hit = (idx_q < cnt_ext) && rdata_q[39:8] == key_q;

	assign emit_lim = (int'(cnt_ext) > chrl_pkg::MAX_OUT) ? 5'(chrl_pkg::MAX_OUT) :
		5'(cnt_ext);
	assign out_load = ((state_q == chrl_pkg::S_DECIDE) && out_free &&
		(op_q != chrl_pkg::OP_LOOKUP || count_q == '0)) ||
		((state_q == chrl_pkg::S_EMIT) && rd_pend_q && out_free);
	assign emit_hold = (state_q == chrl_pkg::S_EMIT) && rd_pend_q && !out_free;

	// Memory port control and next state.
	always_comb begin
		state_d = state_q;
		ren = 1'b0;
		raddr = cur_q[AW-1:0];
		wen = 1'b0;
		waddr = cur_q[AW-1:0];
		wdata = rdata_q;
		case (state_q)
			chrl_pkg::S_IDLE: begin
				if (accept && last_byte) begin
					state_d = chrl_pkg::S_SEARCH;
				end
			end
			chrl_pkg::S_SEARCH: begin
				if (rd_pend_q && ge_key) begin
					state_d = chrl_pkg::S_DECIDE;
				end else if (cur_q >= cnt_ext) begin
					if (!rd_pend_q || !ge_key) begin
						state_d = chrl_pkg::S_DECIDE;
					end
				end else begin
					ren = 1'b1;
				end
			end
			chrl_pkg::S_DECIDE: begin
				if (out_free) begin
					state_d = chrl_pkg::S_OUT;
					case (op_q)
						chrl_pkg::OP_ADD: begin
							if (hit) begin
								wen = 1'b1;
								waddr = idx_q[AW-1:0];
								wdata = {key_q, nid_q};
							end else if (cnt_ext < RING_ENTRIES[CW:0]) begin
								state_d = chrl_pkg::S_SHIFT;
							end
						end
						chrl_pkg::OP_REMOVE: begin
							if (hit) begin
								state_d = chrl_pkg::S_SHIFT;
							end
						end
						chrl_pkg::OP_LOOKUP: begin
							if (count_q != '0) begin
								state_d = chrl_pkg::S_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			chrl_pkg::S_SHIFT: begin
				if (op_q == chrl_pkg::OP_ADD) begin
					if (cur_q == idx_q) begin
						wen = 1'b1;
						waddr = idx_q[AW-1:0];
						wdata = {key_q, nid_q};
						state_d = chrl_pkg::S_OUT;
					end else if (rd_pend_q) begin
						wen = 1'b1;
						waddr = cur_q[AW-1:0];
					end else begin
						ren = 1'b1;
						raddr = AW'(cur_q - 1'b1);
					end
				end else begin
					if (cur_q >= cnt_ext) begin
						state_d = chrl_pkg::S_OUT;
					end else if (rd_pend_q) begin
						wen = 1'b1;
						waddr = cur_q[AW-1:0];
					end else begin
						ren = 1'b1;
						raddr = AW'(cur_q + 1'b1);
					end
				end
			end
			chrl_pkg::S_EMIT: begin
				if (rd_pend_q) begin
					if (out_free) begin
						if (left_q == 5'd1) begin
							state_d = chrl_pkg::S_IDLE;
						end else begin
							ren = 1'b1;
						end
					end
				end else begin
					ren = 1'b1;
				end
			end
			chrl_pkg::S_OUT: begin
				state_d = chrl_pkg::S_IDLE;
			end
			default: state_d = chrl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chrl_pkg::S_IDLE;
			hash_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
			rd_pend_q <= 1'b0;
			cur_q <= '0;
			idx_q <= '0;
			left_q <= '0;
		end else begin
			state_q <= state_d;
			rd_pend_q <= ren || emit_hold;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				chrl_pkg::S_IDLE: begin
					if (accept) begin
						hash_q <= last_byte ? '0 : hash_next;
						cur_q <= '0;
					end
				end
				chrl_pkg::S_SEARCH: begin
					if (rd_pend_q && ge_key) begin
						idx_q <= cur_q - 1'b1;
					end else if (cur_q >= cnt_ext) begin
						idx_q <= cnt_ext;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				chrl_pkg::S_DECIDE: begin
					if (out_free) begin
						if (op_q == chrl_pkg::OP_ADD) begin
							cur_q <= cnt_ext;
							if (!hit && cnt_ext < RING_ENTRIES[CW:0]) begin
								count_q <= count_q + 1'b1;
							end
						end else if (op_q == chrl_pkg::OP_REMOVE) begin
							cur_q <= idx_q;
							if (hit) begin
								count_q <= count_q - 1'b1;
							end
						end else begin
							cur_q <= (idx_q >= cnt_ext) ? '0 : idx_q;
							if (want_q == '0) begin
								left_q <= 5'd1;
							end else if (want_q > emit_lim) begin
								left_q <= emit_lim;
							end else begin
								left_q <= want_q;
							end
						end
						if (op_q != chrl_pkg::OP_LOOKUP || count_q == '0) begin
							last_result <= 1'b1;
							found_node <= '0;
							if (op_q == chrl_pkg::OP_ADD) begin
								status <= hit ? chrl_pkg::ST_OK :
									(cnt_ext < RING_ENTRIES[CW:0]) ? chrl_pkg::ST_OK :
									chrl_pkg::ST_FULL;
								entry_count <= sat5((!hit && cnt_ext < RING_ENTRIES[CW:0]) ?
									cnt_ext + 1'b1 : cnt_ext);
							end else if (op_q == chrl_pkg::OP_REMOVE) begin
								status <= hit ? chrl_pkg::ST_OK : chrl_pkg::ST_ABSENT;
								entry_count <= sat5(hit ? cnt_ext - 1'b1 : cnt_ext);
							end else begin
								status <= hit ? chrl_pkg::ST_OK : chrl_pkg::ST_ABSENT;
								entry_count <= sat5(cnt_ext);
							end
						end
					end
				end
				chrl_pkg::S_SHIFT: begin
					if (op_q == chrl_pkg::OP_ADD) begin
						if (cur_q != idx_q && rd_pend_q) begin
							cur_q <= cur_q - 1'b1;
						end
					end else if (cur_q + 1'b1 < cnt_ext + 1'b1 && rd_pend_q) begin
						cur_q <= cur_q + 1'b1;
					end
				end
				chrl_pkg::S_EMIT: begin
					if (!rd_pend_q || out_free) begin
						if (rd_pend_q) begin
							status <= chrl_pkg::ST_OK;
							found_node <= rdata_q[7:0];
							entry_count <= sat5(cnt_ext);
							last_result <= (left_q == 5'd1);
							left_q <= left_q - 1'b1;
						end
						if (!rd_pend_q || left_q != 5'd1) begin
							cur_q <= (cur_q + 1'b1 >= cnt_ext) ? '0 : cur_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Operands of the final request are captured with its last byte.
	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			key_q <= hash_next;
			op_q <= op;
			nid_q <= node_id;
			want_q <= replicas;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= RING_ENTRIES[CW:0])
		else $error("ring count above capacity");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != chrl_pkg::S_IDLE) |-> !in_ready)
		else $error("request taken while busy");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chrl_pkg::S_IDLE) |=> (count_q == $past(count_q)))
		else $error("ring count changed while idle");
endmodule
`default_nettype wire

### test/chrl_checker.sv
// Checker for the consistent hash ring lookup block: watches both channels,
// predicts results from accepted requests and compares them. Uses chrl_pkg.
`timescale 1ns / 1ps
module chrl_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [1:0] op,
	input  wire logic [7:0] key_byte,
	input  wire logic       last_byte,
	input  wire logic [7:0] node_id,
	input  wire logic [4:0] replicas,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [1:0] status,
	input  wire logic [7:0] found_node,
	input  wire logic [4:0] entry_count,
	input  wire logic       last_result,
	output int              fail_count,
	output int              pending
);
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] node;
		logic [4:0] count;
		logic       last;
	} ring_result_t;

	ring_result_t expected_results[$];
	logic [31:0] hash_acc;
	logic [31:0] pos[16];
	logic [7:0] ids[16];
	int ring_size;

	assign pending = expected_results.size();

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic add_expected(input ring_result_t r);
		expected_results = {expected_results, r};
	endtask

	function automatic ring_result_t mk(logic [1:0] s, logic [7:0] n, logic l);
		ring_result_t r;
		r.status = s;
		r.node = n;
		r.count = 5'(ring_size);
		r.last = l;
		return r;
	endfunction

	task automatic predict_ring_op(input logic [1:0] code, input logic [31:0] h,
			input logic [7:0] nid, input logic [4:0] want);
		int idx;
		int n;
		bit hit;
		idx = 0;
		while (idx < ring_size && $signed(pos[idx]) < $signed(h))
			idx++;
		hit = idx < ring_size && pos[idx] == h;
		case (code)
			chrl_pkg::OP_ADD: begin
				if (hit) begin
					ids[idx] = nid;
					add_expected(mk(chrl_pkg::ST_OK, 8'd0, 1'b1));
				end else if (ring_size >= 16) begin
					add_expected(mk(chrl_pkg::ST_FULL, 8'd0, 1'b1));
				end else begin
					for (int i = ring_size; i > idx; i--) begin
						pos[i] = pos[i - 1];
						ids[i] = ids[i - 1];
					end
					pos[idx] = h;
					ids[idx] = nid;
					ring_size++;
					add_expected(mk(chrl_pkg::ST_OK, 8'd0, 1'b1));
				end
			end
			chrl_pkg::OP_REMOVE: begin
				if (hit) begin
					for (int i = idx; i + 1 < ring_size; i++) begin
						pos[i] = pos[i + 1];
						ids[i] = ids[i + 1];
					end
					ring_size--;
					add_expected(mk(chrl_pkg::ST_OK, 8'd0, 1'b1));
				end else begin
					add_expected(mk(chrl_pkg::ST_ABSENT, 8'd0, 1'b1));
				end
			end
			chrl_pkg::OP_CONTAINS:
				add_expected(mk(hit ? chrl_pkg::ST_OK : chrl_pkg::ST_ABSENT, 8'd0, 1'b1));
			default: begin
				if (ring_size == 0) begin
					add_expected(mk(chrl_pkg::ST_ABSENT, 8'd0, 1'b1));
				end else begin
					if (idx >= ring_size)
						idx = 0;
					n = (want == 0) ? 1 : int'(want);
					if (n > ring_size)
						n = ring_size;
					for (int i = 0; i < n; i++)
						add_expected(
							mk(chrl_pkg::ST_OK, ids[(idx + i) % ring_size], i + 1 == n));
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_result_t exp_r;
		logic [31:0] h;
		if (!arst_n) begin
			hash_acc = 0;
			ring_size = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected");
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.status)
						report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
					if (found_node !== exp_r.node)
						report_mismatch($sformatf("found_node %0d, want %0d",
							found_node, exp_r.node));
					if (entry_count !== exp_r.count)
						report_mismatch($sformatf("entry_count %0d, want %0d",
							entry_count, exp_r.count));
					if (last_result !== exp_r.last)
						report_mismatch($sformatf("last_result %0d, want %0d",
							last_result, exp_r.last));
				end
			end
			if (in_valid && in_ready) begin
				h = hash_acc * 32'd31 + 32'(key_byte);
				hash_acc = h;
				if (last_byte) begin
					hash_acc = 0;
					predict_ring_op(op, h, node_id, replicas);
				end
			end
		end
	end
endmodule

### test/tb_consistent_hash_ring_lookup.sv
// Testbench top for the consistent hash ring lookup block: drives requests with
// random gaps and stalls and gives the verdict. Depends on chrl_checker, chrl_pkg.
`timescale 1ns / 1ps
module tb_consistent_hash_ring_lookup;
	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] op;
	logic [7:0] key_byte, node_id;
	logic last_byte;
	logic [4:0] replicas;
	logic [1:0] status;
	logic [7:0] found_node;
	logic [4:0] entry_count;
	logic last_result;
	int fail_count, pending, idle_cycles;
	bit stall_free;
	logic [7:0] node_keys[24][3];

	consistent_hash_ring_lookup dut (.*);
	chrl_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		if (stall_free)
			return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
	endfunction

	task automatic send_byte(input logic [1:0] o, input logic [7:0] b, input logic l,
			input logic [7:0] nid, input logic [4:0] rep);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		op <= o;
		key_byte <= b;
		last_byte <= l;
		node_id <= nid;
		replicas <= rep;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic idle_input();
		in_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_key(input logic [1:0] o, input int k, input int nbytes,
			input logic [7:0] nid, input logic [4:0] rep);
		for (int i = 0; i < nbytes; i++)
			send_byte(o, node_keys[k][i], i == nbytes - 1, nid, rep);
	endtask

	task automatic send_random_op();
		chrl_pkg::op_t o;
		int k;
		o = chrl_pkg::op_t'($urandom_range(0, 3));
		k = $urandom_range(0, 23);
		if ($urandom_range(0, 9) == 0)
			send_byte(o, 8'($urandom), 1, 8'($urandom), 5'($urandom));
		else
			send_key(o, k, 1 + k % 3, 8'($urandom), 5'($urandom_range(0, 31)));
	endtask

	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
			idle_cycles++;
			if (idle_cycles > 20000) begin
				$display("tb_consistent_hash_ring_lookup: errors");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (stall_free || $urandom_range(0, 3) != 0) begin
				out_ready <= 1;
			end else begin
				out_ready <= 0;
				repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 2)
						: $urandom_range(5, 40)) @(negedge clk);
				out_ready <= 1;
			end
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		op = chrl_pkg::OP_ADD;
		key_byte = 0;
		last_byte = 0;
		node_id = 0;
		replicas = 0;
		idle_cycles = 0;
		stall_free = 0;
		for (int i = 0; i < 24; i++)
			for (int j = 0; j < 3; j++)
				node_keys[i][j] = 8'($urandom);
		node_keys[0] = '{8'h00, 8'h00, 8'h00};
		node_keys[1] = '{8'hFF, 8'hFF, 8'hFF};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_key(chrl_pkg::OP_LOOKUP, 3, 2, 0, 1);
		send_key(chrl_pkg::OP_REMOVE, 3, 2, 0, 0);
		send_key(chrl_pkg::OP_CONTAINS, 3, 2, 0, 0);
		for (int k = 0; k < 17; k++)
			send_key(chrl_pkg::OP_ADD, k, 3, 8'(k * 15 + 1), 0);
		send_key(chrl_pkg::OP_ADD, 2, 3, 8'hFF, 0);
		send_key(chrl_pkg::OP_LOOKUP, 1, 3, 0, 0);
		send_key(chrl_pkg::OP_LOOKUP, 0, 3, 0, 5'd31);
		send_key(chrl_pkg::OP_CONTAINS, 4, 3, 0, 0);
		send_key(chrl_pkg::OP_REMOVE, 4, 3, 0, 0);
		send_key(chrl_pkg::OP_LOOKUP, 5, 1, 0, 16);

		idle_input();
		stall_free = 1;
		wait (pending == 0);
		@(negedge clk);
		stall_free = 0;

		for (int i = 0; i < 130; i++) begin
			send_random_op();
			if (i == 80) begin
				idle_input();
				wait (pending == 0);
				@(negedge clk);
				for (int k = 0; k < 24; k++)
					send_key(chrl_pkg::OP_REMOVE, k, 1 + k % 3, 0, 0);
			end
		end

		idle_input();
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_consistent_hash_ring_lookup: clean");
		else
			$display("tb_consistent_hash_ring_lookup: errors");
		$finish;
	end
endmodule
